/* hdl/mplpd_pkg.sv */
package mplpd_pkg;

   // Request function codes
   typedef enum logic [1:0] {
      FN_PRESS = 2'd0,
      FN_POLL  = 2'd1,
      FN_CLEAR = 2'd2,
      FN_NOP   = 2'd3
   } func_type;

   // Per-entry press tracking phase
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESSED = 2'd1,
      PH_LATCHED = 2'd2
   } phase_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POLL = 1'b1
   } state_type;

   // Register file port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_BASE   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT       = 4'd8;

   typedef struct packed {
      func_type    func;
      logic [31:0] now_time;
      logic [7:0]  action_in;
      logic [1:0]  pad_num;
      logic [4:0]  button_code;
      logic [3:0]  pads_connected;
      logic [31:0] buttons_pad0;
      logic [31:0] buttons_pad1;
      logic [31:0] buttons_pad2;
      logic [31:0] buttons_pad3;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_pad;
      logic [4:0] event_button;
      logic [7:0] event_action;
      logic       held;
   } rsp_payload_type;

   // Status from the shared age/button unit
   typedef struct packed {
      logic down;
      logic expired;
   } age_result_type;

endpackage

/* hdl/mplpd_age_unit.sv */
module mplpd_age_unit (
   input  logic [31:0]                 now_time,
   input  logic [31:0]                 stamp,
   input  logic [31:0]                 hold,
   input  logic [31:0]                 buttons,
   input  logic [4:0]                  button,
   output mplpd_pkg::age_result_type   result
);

   logic [31:0] age;

   // Press age wraps modulo 2^32
   assign age = now_time - stamp;

   always_comb begin
      result.expired = (age >= hold);
      result.down    = buttons[button];
   end

endmodule

/* hdl/multi_pad_long_press_detector.sv */
// Long-press detector for NUM_SLOTS action slots across NUM_PADS pads.
// req_*: one request per transfer. func selects press event, poll, clear
//   or no-op. Press, clear and no-op are absorbed in the accepting
//   cycle; they can arrive every cycle while idle with csr_valid low.
// Poll: the sequencer visits one pad/slot entry per cycle through the
//   shared age/button unit, pads outer, slots inner, unless held by a
//   stalled result. A poll holds the block until its walk ends and yields
//   at most one rsp_* transfer, registered as the reporting entry
//   commits. A poll with nothing to report yields none.
// csr_*: register index and data; indexes 0-3 are slot action codes,
//   4-7 slot hold times in ticks. Any write within the list idles all
//   entries. Writes are taken only while no poll is running.
// rsp_*: output register. A new request is taken while a result waits;
//   if a later poll reaches a reporting entry while the previous result
//   is still stalled, the walk holds on that entry until rsp_ready.
// Synchronous reset: entries idle, slot registers zero, sequencer idle.
module multi_pad_long_press_detector #(
   parameter int NUM_PADS  = 4,
   parameter int NUM_SLOTS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mplpd_pkg::req_payload_type             req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mplpd_pkg::rsp_payload_type             rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mplpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mplpd_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int PAD_W  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [PAD_W-1:0]  LAST_PAD   = PAD_W'(NUM_PADS - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [2:0]        PAD_LIMIT  = 3'(NUM_PADS);
   localparam logic [2:0]        SLOT_LIMIT = 3'(NUM_SLOTS);

   // Sequencer and walk registers
   mplpd_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [PAD_W-1:0]     pad_ff, pad_in;

   // Poll operands captured at accept
   logic [31:0]          now_ff;
   logic [NUM_PADS-1:0]  conn_ff;
   logic [31:0]          mask_ff [NUM_PADS];

   // Slot registers
   logic [7:0]           action_ff [NUM_SLOTS];
   logic [31:0]          hold_ff   [NUM_SLOTS];

   // Entry store
   mplpd_pkg::phase_type phase_ff  [NUM_SLOTS][NUM_PADS];
   logic [31:0]          stamp_ff  [NUM_SLOTS][NUM_PADS];
   logic [4:0]           button_ff [NUM_SLOTS][NUM_PADS];

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   mplpd_pkg::rsp_payload_type rsp_payload_ff;

   logic                  req_fire, csr_fire, wipe;
   logic [31:0]           req_masks [4];
   logic                  press_hit, pad_ok, press_we;
   logic [SLOT_W-1:0]     press_slot;
   logic [PAD_W-1:0]      press_pad;
   logic [1:0]            csr_slot;
   logic                  csr_slot_ok;
   mplpd_pkg::phase_type  phase_cur;
   logic [4:0]            button_cur;
   logic                  slot_on, entry_on;
   mplpd_pkg::age_result_type age_res;
   logic                  report_hold, report_rel, clear_latch, report_hit;
   logic                  rsp_busy, commit, advance, walk_last, poll_start;

   assign req_fire = req_valid & req_ready;
   assign csr_fire = csr_valid & csr_ready;

   // Any register write in the list or a clear request idles all entries
   assign wipe = (csr_fire & (csr_index < mplpd_pkg::CSR_COUNT)) |
                 (req_fire & (req_payload.func == mplpd_pkg::FN_CLEAR));

   assign poll_start = req_fire & (req_payload.func == mplpd_pkg::FN_POLL);

   always_comb begin
      req_masks[0] = req_payload.buttons_pad0;
      req_masks[1] = req_payload.buttons_pad1;
      req_masks[2] = req_payload.buttons_pad2;
      req_masks[3] = req_payload.buttons_pad3;
   end

   // Press: lowest enabled slot with a matching action code
   always_comb begin
      press_hit  = 1'b0;
      press_slot = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if ((hold_ff[s] != 32'd0) && (action_ff[s] == req_payload.action_in)) begin
            press_hit  = 1'b1;
            press_slot = SLOT_W'(s);
         end
      end
   end

   assign pad_ok    = ({1'b0, req_payload.pad_num} < PAD_LIMIT);
   assign press_pad = req_payload.pad_num[PAD_W-1:0];
   assign press_we  = req_fire & (req_payload.func == mplpd_pkg::FN_PRESS) &
                      press_hit & pad_ok;

   // Register index decode
   always_comb begin
      if (csr_index < mplpd_pkg::CSR_HOLD_BASE) begin
         csr_slot = 2'(csr_index - mplpd_pkg::CSR_ACTION_BASE);
      end else begin
         csr_slot = 2'(csr_index - mplpd_pkg::CSR_HOLD_BASE);
      end
      csr_slot_ok = ({1'b0, csr_slot} < SLOT_LIMIT);
   end

   // Current walk entry
   assign phase_cur  = phase_ff[slot_ff][pad_ff];
   assign button_cur = button_ff[slot_ff][pad_ff];
   assign slot_on    = (hold_ff[slot_ff] != 32'd0);
   assign entry_on   = (state_ff == mplpd_pkg::ST_POLL) & conn_ff[pad_ff] & slot_on;

   mplpd_age_unit u_age (
      .now_time (now_ff),
      .stamp    (stamp_ff[slot_ff][pad_ff]),
      .hold     (hold_ff[slot_ff]),
      .buttons  (mask_ff[pad_ff]),
      .button   (button_cur),
      .result   (age_res)
   );

   // Entry decision
   always_comb begin
      report_hold = entry_on & age_res.down & (phase_cur == mplpd_pkg::PH_PRESSED) &
                    age_res.expired;
      report_rel  = entry_on & ~age_res.down & (phase_cur == mplpd_pkg::PH_PRESSED);
      clear_latch = entry_on & ~age_res.down & (phase_cur == mplpd_pkg::PH_LATCHED);
      report_hit  = report_hold | report_rel;
   end

   assign rsp_busy  = rsp_valid_ff & ~rsp_ready;
   assign commit    = report_hit & ~rsp_busy;
   assign advance   = (state_ff == mplpd_pkg::ST_POLL) & ~report_hit;
   assign walk_last = (slot_ff == LAST_SLOT) && (pad_ff == LAST_PAD);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mplpd_pkg::ST_IDLE: begin
            if (poll_start) state_in = mplpd_pkg::ST_POLL;
         end
         mplpd_pkg::ST_POLL: begin
            if (commit || (advance && walk_last)) state_in = mplpd_pkg::ST_IDLE;
         end
         default: state_in = mplpd_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshakes and walk counters
   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      slot_in   = slot_ff;
      pad_in    = pad_ff;
      case (state_ff)
         mplpd_pkg::ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = ~csr_valid;
            if (poll_start) begin
               slot_in = '0;
               pad_in  = '0;
            end
         end
         mplpd_pkg::ST_POLL: begin
            if (advance) begin
               if (slot_ff == LAST_SLOT) begin
                  slot_in = '0;
                  pad_in  = pad_ff + 1'b1;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mplpd_pkg::ST_IDLE;
         slot_ff  <= '0;
         pad_ff   <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         pad_ff   <= pad_in;
      end
   end

   // Poll operand capture
   always_ff @(posedge clock) begin
      if (poll_start) begin
         now_ff  <= req_payload.now_time;
         conn_ff <= req_payload.pads_connected[NUM_PADS-1:0];
         for (int p = 0; p < NUM_PADS; p++) begin
            mask_ff[p] <= req_masks[p];
         end
      end
   end

   // Slot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            action_ff[s] <= '0;
            hold_ff[s]   <= '0;
         end
      end else if (csr_fire && csr_slot_ok) begin
         if (csr_index < mplpd_pkg::CSR_HOLD_BASE) begin
            action_ff[csr_slot[SLOT_W-1:0]] <= csr_data[7:0];
         end else if (csr_index < mplpd_pkg::CSR_COUNT) begin
            hold_ff[csr_slot[SLOT_W-1:0]] <= csr_data;
         end
      end
   end

   // Entry phases
   always_ff @(posedge clock) begin
      if (reset || wipe) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int p = 0; p < NUM_PADS; p++) begin
               phase_ff[s][p] <= mplpd_pkg::PH_IDLE;
            end
         end
      end else begin
         if (press_we) phase_ff[press_slot][press_pad] <= mplpd_pkg::PH_PRESSED;
         if (commit) begin
            phase_ff[slot_ff][pad_ff] <= report_hold ? mplpd_pkg::PH_LATCHED
                                                     : mplpd_pkg::PH_IDLE;
         end else if (clear_latch) begin
            phase_ff[slot_ff][pad_ff] <= mplpd_pkg::PH_IDLE;
         end
      end
   end

   // Entry payload, read only while the phase is not idle
   always_ff @(posedge clock) begin
      if (press_we) begin
         stamp_ff[press_slot][press_pad]  <= req_payload.now_time;
         button_ff[press_slot][press_pad] <= req_payload.button_code;
      end
   end

   // Output register
   assign rsp_valid_in = commit | rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_payload_ff.event_pad    <= 2'(pad_ff);
         rsp_payload_ff.event_button <= button_cur;
         rsp_payload_ff.event_action <= action_ff[slot_ff];
         rsp_payload_ff.held         <= report_hold;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A result only appears as a poll walk finishes
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == mplpd_pkg::ST_POLL) &&
                              (state_ff == mplpd_pkg::ST_IDLE))
      else $error("result loaded outside a poll walk");

   // A live entry always belongs to an enabled slot
   a_live_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mplpd_pkg::ST_POLL) && (phase_cur != mplpd_pkg::PH_IDLE) |-> slot_on)
      else $error("active entry in a disabled slot");

   // A hold report latches its entry
   a_latch_commit: assert property (@(posedge clock) disable iff (reset)
      commit && report_hold |=>
         phase_ff[$past(slot_ff)][$past(pad_ff)] == mplpd_pkg::PH_LATCHED)
      else $error("reported hold did not latch");

   // Walk holds on a reporting entry while the output is stalled
   a_walk_stall: assert property (@(posedge clock) disable iff (reset)
      report_hit && rsp_busy |=> $stable(slot_ff) && $stable(pad_ff) &&
                                 (state_ff == mplpd_pkg::ST_POLL))
      else $error("walk moved past an unreported entry");

endmodule

/* bench/multi_pad_long_press_detector_tb.sv */
module multi_pad_long_press_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 75;
   localparam int RANDOM_PHASES = 6;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_ready;
   mplpd_pkg::req_payload_type        req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_ready   = 1'b0;
   mplpd_pkg::rsp_payload_type        rsp_payload;
   logic                              csr_valid   = 1'b0;
   logic                              csr_ready;
   logic [mplpd_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [mplpd_pkg::CSR_DATA_W-1:0]  csr_data    = '0;

   multi_pad_long_press_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Slot table and press entries as the block should hold them (entry = slot*4 + pad)
   logic [7:0]           slot_action  [4]  = '{default: '0};
   logic [31:0]          slot_hold    [4]  = '{default: '0};
   mplpd_pkg::phase_type entry_phase  [16] = '{default: mplpd_pkg::PH_IDLE};
   logic [31:0]          entry_stamp  [16] = '{default: '0};
   logic [4:0]           entry_button [16] = '{default: '0};
   logic [1:0]           entry_pad    [16] = '{default: '0};

   mplpd_pkg::req_payload_type request_backlog [$];
   mplpd_pkg::rsp_payload_type awaited_events  [$];

   // Stimulus generator state: running tick count and buttons held per pad
   logic [31:0] tick_now            = 32'hFFFF_F000;
   logic [31:0] held_mask [4]       = '{default: '0};

   int   failures    = 0;
   int   send_gap    = 0;
   int   take_stall  = 0;
   int   idle_cycles = 0;
   logic calm_tail   = 1'b0;

   function automatic void forget_presses();
      for (int e = 0; e < 16; e++) begin
         entry_phase[e]  = mplpd_pkg::PH_IDLE;
         entry_stamp[e]  = '0;
         entry_button[e] = '0;
         entry_pad[e]    = '0;
      end
   endfunction

   // Register write: any index inside the table redefines the slots
   function automatic void apply_register(input logic [3:0] idx, input logic [31:0] val);
      if (idx < mplpd_pkg::CSR_HOLD_BASE) begin
         slot_action[idx[1:0]] = val[7:0];
         forget_presses();
      end else if (idx < mplpd_pkg::CSR_COUNT) begin
         slot_hold[idx[1:0]] = val;
         forget_presses();
      end
   endfunction

   // Advance the press entries by one request; returns 1 when a poll reports an event
   function automatic bit track_request(input mplpd_pkg::req_payload_type item,
                                        output mplpd_pkg::rsp_payload_type ev);
      logic [31:0] masks [4];
      logic [31:0] age;
      bit          found;
      bit          down;
      int          e;
      found = 1'b0;
      ev = '0;
      masks[0] = item.buttons_pad0;
      masks[1] = item.buttons_pad1;
      masks[2] = item.buttons_pad2;
      masks[3] = item.buttons_pad3;
      case (item.func)
         mplpd_pkg::FN_PRESS: begin
            // lowest enabled slot with a matching code takes the press
            for (int s = 0; s < 4; s++) begin
               if (!found && slot_hold[s] != 0 && slot_action[s] == item.action_in) begin
                  e = s * 4 + item.pad_num;
                  entry_phase[e]  = mplpd_pkg::PH_PRESSED;
                  entry_stamp[e]  = item.now_time;
                  entry_button[e] = item.button_code;
                  entry_pad[e]    = item.pad_num;
                  found = 1'b1;
               end
            end
            found = 1'b0;
         end
         mplpd_pkg::FN_CLEAR: forget_presses();
         mplpd_pkg::FN_POLL: begin
            // pads outer, slots inner, first reporting entry ends the walk
            for (int p = 0; p < 4; p++) begin
               for (int s = 0; s < 4; s++) begin
                  if (!found && item.pads_connected[p] && slot_hold[s] != 0) begin
                     e = s * 4 + p;
                     down = masks[p][entry_button[e]];
                     age = item.now_time - entry_stamp[e];
                     if (down) begin
                        if (entry_phase[e] == mplpd_pkg::PH_PRESSED &&
                            age >= slot_hold[s]) begin
                           entry_phase[e] = mplpd_pkg::PH_LATCHED;
                           ev = '{entry_pad[e], entry_button[e], slot_action[s], 1'b1};
                           found = 1'b1;
                        end
                     end else if (entry_phase[e] == mplpd_pkg::PH_PRESSED) begin
                        entry_phase[e] = mplpd_pkg::PH_IDLE;
                        ev = '{entry_pad[e], entry_button[e], slot_action[s], 1'b0};
                        found = 1'b1;
                     end else if (entry_phase[e] == mplpd_pkg::PH_LATCHED) begin
                        entry_phase[e] = mplpd_pkg::PH_IDLE;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return found;
   endfunction

   function automatic void queue_request(input mplpd_pkg::func_type fn, input logic [31:0] at,
                                         input logic [7:0] code, input logic [1:0] pad,
                                         input logic [4:0] btn, input logic [3:0] conn,
                                         input logic [31:0] m0, input logic [31:0] m1,
                                         input logic [31:0] m2, input logic [31:0] m3);
      mplpd_pkg::req_payload_type item;
      item = '{fn, at, code, pad, btn, conn, m0, m1, m2, m3};
      request_backlog = {request_backlog, item};
   endfunction

   // Mostly presses on watched codes and polls with evolving button state, some noise
   function automatic mplpd_pkg::req_payload_type next_random_request();
      mplpd_pkg::req_payload_type item;
      int pick;
      int slot;
      int pad;
      int btn;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0)
         tick_now = $urandom();
      else
         tick_now += $urandom_range(0, 12);
      item.func           = mplpd_pkg::func_type'($urandom_range(0, 3));
      item.now_time       = tick_now;
      item.action_in      = 8'($urandom());
      item.pad_num        = 2'($urandom());
      item.button_code    = 5'($urandom());
      item.pads_connected = 4'($urandom());
      item.buttons_pad0   = $urandom();
      item.buttons_pad1   = $urandom();
      item.buttons_pad2   = $urandom();
      item.buttons_pad3   = $urandom();
      if (pick < 38) begin
         slot = $urandom_range(0, 3);
         pad  = $urandom_range(0, 3);
         btn  = $urandom_range(0, 31);
         item.func        = mplpd_pkg::FN_PRESS;
         item.action_in   = slot_action[slot];
         item.pad_num     = 2'(pad);
         item.button_code = 5'(btn);
         held_mask[pad][btn] = 1'b1;
      end else if (pick < 82) begin
         item.func = mplpd_pkg::FN_POLL;
         if ($urandom_range(0, 3) != 0)
            item.pads_connected = 4'hF;
         for (int p = 0; p < 4; p++) begin
            if ($urandom_range(0, 9) == 0)
               held_mask[p] = $urandom();
            else
               held_mask[p] &= $urandom() | $urandom();
         end
         item.buttons_pad0 = held_mask[0];
         item.buttons_pad1 = held_mask[1];
         item.buttons_pad2 = held_mask[2];
         item.buttons_pad3 = held_mask[3];
      end else if (pick < 85) begin
         item.func = mplpd_pkg::FN_CLEAR;
      end
      return item;
   endfunction

   // Called at a rising edge; returns at the edge where the write transfer happens
   task automatic write_register(input logic [3:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, val);
   endtask

   // Whole slot table, starting at a random register, optionally a write past the table
   task automatic program_slots(input logic [7:0] codes [4], input logic [31:0] holds [4],
                                input bit stray_write);
      int start;
      int reg_idx;
      start = $urandom_range(0, 7);
      @(posedge clock);
      for (int k = 0; k < 8; k++) begin
         reg_idx = (start + k) % 8;
         if (reg_idx < 4)
            write_register(mplpd_pkg::CSR_ACTION_BASE + 4'(reg_idx),
                           {24'($urandom()), codes[reg_idx]});
         else
            write_register(mplpd_pkg::CSR_HOLD_BASE + 4'(reg_idx - 4), holds[reg_idx - 4]);
      end
      if (stray_write)
         write_register(mplpd_pkg::CSR_COUNT + 4'($urandom_range(0, 7)), $urandom());
      csr_valid <= 1'b0;
   endtask

   // Block is idle once all requests went out, all events came back and a poll walk had time
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || awaited_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver with random gaps
   always @(posedge clock) begin : drive_requests
      mplpd_pkg::rsp_payload_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (track_request(req_payload, predicted))
               awaited_events = {awaited_events, predicted};
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm_tail && request_backlog.size() != 0 &&
                         $urandom_range(0, 9) == 0) begin
               send_gap  <= $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_payload <= request_backlog.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Event monitor with random back-pressure
   always @(posedge clock) begin : check_events
      mplpd_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_events.size() == 0) begin
               $error("unexpected event: pad %0d button %0d action %0h held %0b",
                      rsp_payload.event_pad, rsp_payload.event_button,
                      rsp_payload.event_action, rsp_payload.held);
               failures++;
            end else begin
               want = awaited_events.pop_front();
               if (rsp_payload.event_pad !== want.event_pad) begin
                  $error("event_pad: expected %0d, got %0d",
                         want.event_pad, rsp_payload.event_pad);
                  failures++;
               end
               if (rsp_payload.event_button !== want.event_button) begin
                  $error("event_button: expected %0d, got %0d",
                         want.event_button, rsp_payload.event_button);
                  failures++;
               end
               if (rsp_payload.event_action !== want.event_action) begin
                  $error("event_action: expected %0h, got %0h",
                         want.event_action, rsp_payload.event_action);
                  failures++;
               end
               if (rsp_payload.held !== want.held) begin
                  $error("held: expected %0b, got %0b", want.held, rsp_payload.held);
                  failures++;
               end
            end
         end
         if (take_stall > 0) begin
            take_stall <= take_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            take_stall <= $urandom_range(0, 15);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_sequence
      logic [7:0]  codes [4];
      logic [31:0] holds [4];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: slot 1 and disabled slot 3 share a code, slot 2 has the longest hold
      codes = '{8'h00, 8'hFF, 8'h5A, 8'hFF};
      holds = '{32'd1, 32'd5, 32'hFFFF_FFFF, 32'd0};
      program_slots(codes, holds, 1'b1);
      @(negedge clock);
      // press, then: pad not connected, too young, hold reached, latched, released
      queue_request(mplpd_pkg::FN_PRESS, 32'd100, 8'h00, 2'd0, 5'd0, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd101, 8'h00, 2'd0, 5'd0, 4'h0, '1, '1, '1, '1);
      queue_request(mplpd_pkg::FN_POLL, 32'd100, 8'h00, 2'd0, 5'd0, 4'hF, 32'h1, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd101, 8'h00, 2'd0, 5'd0, 4'hF, 32'h1, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd300, 8'h00, 2'd0, 5'd0, 4'hF, '1, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd301, 8'h00, 2'd0, 5'd0, 4'hF, '0, '0, '0, '0);
      // top button on the last pad, age across the tick wrap
      queue_request(mplpd_pkg::FN_PRESS, 32'hFFFF_FFF0, 8'hFF, 2'd3, 5'd31, 4'h0,
                    '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd3, 8'h00, 2'd0, 5'd0, 4'h8,
                    '0, '0, '0, 32'h8000_0000);
      // repeated press on a latched entry, then released before the hold time
      queue_request(mplpd_pkg::FN_PRESS, 32'd10, 8'hFF, 2'd3, 5'd31, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd11, 8'h00, 2'd0, 5'd0, 4'h8, '0, '0, '0, '0);
      // maximum hold: one tick short, then exactly reached
      queue_request(mplpd_pkg::FN_PRESS, 32'd1000, 8'h5A, 2'd1, 5'd7, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd998, 8'h00, 2'd0, 5'd0, 4'h2, '0, 32'h80, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd999, 8'h00, 2'd0, 5'd0, 4'h2, '0, 32'h80, '0, '0);
      // code nobody watches
      queue_request(mplpd_pkg::FN_PRESS, 32'd5, 8'h77, 2'd2, 5'd1, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd50, 8'h00, 2'd0, 5'd0, 4'hF, '0, '0, '0, '0);
      // second press overwrites the first on the same entry
      queue_request(mplpd_pkg::FN_PRESS, 32'd60, 8'h00, 2'd2, 5'd3, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_PRESS, 32'd61, 8'h00, 2'd2, 5'd4, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd62, 8'h00, 2'd0, 5'd0, 4'h4, '0, '0, 32'h8, '0);
      // two ready entries: one event per poll, lower pad first
      queue_request(mplpd_pkg::FN_PRESS, 32'd70, 8'h00, 2'd1, 5'd2, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_PRESS, 32'd70, 8'hFF, 2'd0, 5'd9, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd80, 8'h00, 2'd0, 5'd0, 4'hF,
                    32'h200, 32'h4, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd80, 8'h00, 2'd0, 5'd0, 4'hF,
                    32'h200, 32'h4, '0, '0);
      // clear drops a pending press
      queue_request(mplpd_pkg::FN_PRESS, 32'd90, 8'h5A, 2'd0, 5'd20, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_CLEAR, 32'd95, 8'h00, 2'd0, 5'd0, 4'h0, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_POLL, 32'd100, 8'h00, 2'd0, 5'd0, 4'hF, '0, '0, '0, '0);
      queue_request(mplpd_pkg::FN_NOP, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      // left pending across the next register write
      queue_request(mplpd_pkg::FN_PRESS, 32'd200, 8'h00, 2'd3, 5'd5, 4'h0, '0, '0, '0, '0);
      wait_until_quiet();

      // Random phases, each but the first with a fresh slot table; the last one without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1)
            calm_tail <= 1'b1;
         if (phase == 0) begin
            // write past the table only: slots and pending presses stay
            @(posedge clock);
            write_register(mplpd_pkg::CSR_COUNT + 4'($urandom_range(0, 7)), $urandom());
            csr_valid <= 1'b0;
         end else begin
            for (int s = 0; s < 4; s++) begin
               codes[s] = ($urandom_range(0, 2) == 0) ? 8'($urandom())
                                                      : 8'(8'h40 + $urandom_range(0, 3));
               case ($urandom_range(0, 9))
                  0:       holds[s] = '0;
                  1:       holds[s] = '1;
                  2:       holds[s] = $urandom();
                  default: holds[s] = $urandom_range(1, 40);
               endcase
            end
            program_slots(codes, holds, 1'($urandom_range(0, 1)));
         end
         @(negedge clock);
         repeat (PHASE_ITEMS) request_backlog = {request_backlog, next_random_request()};
         wait_until_quiet();
      end

      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
hdl/mplpd_pkg.sv
hdl/mplpd_age_unit.sv
hdl/multi_pad_long_press_detector.sv
bench/multi_pad_long_press_detector_tb.sv
